### sv/bsf_pkg.sv
package bsf_pkg;

  // queue depth and derived widths
  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SYM_W = 8;
  localparam int OCC_W = 8;
  localparam int CFG_W = 8;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // register reset values
  localparam logic [CFG_W-1:0] CAP_RESET    = 8'd128;
  localparam logic [CFG_W-1:0] TARGET_RESET = 8'd0;

  // register indexes
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_TARGET   = 1'b1
  } reg_idx_t;

  // operation codes
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_POPPED  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_REMOVED = 3'd4
  } status_t;

  // control sequencer states
  typedef enum logic [0:0] {
    FSM_IDLE   = 1'b0,
    FSM_SECOND = 1'b1
  } fsm_t;

  // control for the whole cell row
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] load_pos;
    logic [SYM_W-1:0] sym;
  } chain_ctrl_t;

  // control seen by a single cell
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [SYM_W-1:0] sym;
  } cell_ctrl_t;

endpackage

### sv/bsf_cell.sv
module bsf_cell (
  input  logic                            clk,
  input  bsf_pkg::cell_ctrl_t             ctrl,
  input  logic [bsf_pkg::SYM_W-1:0]       from_next,
  output logic [bsf_pkg::SYM_W-1:0]       data
);
  import bsf_pkg::*;

  // move toward the head on shift, take the new symbol on load
  always_ff @(posedge clk) begin
    if (ctrl.shift || ctrl.load) begin
      data <= ctrl.load ? ctrl.sym : from_next;
    end
  end

endmodule

### sv/bsf_chain.sv
module bsf_chain (
  input  logic                            clk,
  input  bsf_pkg::chain_ctrl_t            ctrl,
  output logic [bsf_pkg::SYM_W-1:0]       head0,
  output logic [bsf_pkg::SYM_W-1:0]       head1
);
  import bsf_pkg::*;

  logic [SYM_W-1:0] cell_data [DEPTH];

  // row of cells, cell 0 is the head of the queue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t       cc;
    logic [SYM_W-1:0] nb;

    assign cc.shift = ctrl.shift;
    assign cc.load  = ctrl.load && (ctrl.load_pos == IDX_W'(i));
    assign cc.sym   = ctrl.sym;

    if (i == DEPTH - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_data[i+1];
    end

    bsf_cell u_cell (
      .clk       (clk),
      .ctrl      (cc),
      .from_next (nb),
      .data      (cell_data[i])
    );
  end

  assign head0 = cell_data[0];
  assign head1 = cell_data[1];

endmodule

### sv/bounded_symbol_fifo_with_target_drop.sv
// an accepted item's first result is written to the output register in the cycle after it is taken
// throughput: one push, pop or clear per cycle while the output is not stalled;
//   a target push that removes two symbols stalls the input for its second result
// each cycle the whole cell row shifts one place toward the head on a removal
// reset (rst, synchronous) empties the queue, restores capacity 128 and target 0;
//   cell contents are not cleared
module bounded_symbol_fifo_with_target_drop (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [bsf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic [bsf_pkg::SYM_W-1:0]       symbol_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [bsf_pkg::SYM_W-1:0]       symbol_out,
  output logic [bsf_pkg::OCC_W-1:0]       occupancy,
  output logic [bsf_pkg::SYM_W-1:0]       head_symbol,
  output logic                            head_valid,
  output logic                            last
);
  import bsf_pkg::*;

  logic [CFG_W-1:0] capacity;
  logic [CFG_W-1:0] target;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  fsm_t             fsm;
  fsm_t             fsm_next;

  chain_ctrl_t      ctrl;
  logic [SYM_W-1:0] head0;
  logic [SYM_W-1:0] head1;

  logic             slot_free;
  logic             take;
  logic             full;
  logic             emit;
  status_t          e_status;
  logic [SYM_W-1:0] e_sym;
  logic [CNT_W-1:0] e_count;
  logic [SYM_W-1:0] e_head;
  logic             e_last;

  bsf_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .head0 (head0),
    .head1 (head1)
  );

  // handshake
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (fsm == FSM_SECOND) || !slot_free;
  assign take      = in_valid && !in_stall;

  // full when count reaches the capacity, saturated at the depth
  assign full = (CMP_W'(count) >= CMP_W'(capacity)) || (count >= CNT_W'(DEPTH));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      target   <= TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity <= cfg_data;
        REG_TARGET:   target   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // sequencer state and count
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm   <= FSM_IDLE;
      count <= '0;
    end else begin
      fsm   <= fsm_next;
      count <= count_next;
    end
  end

  // operation decode, cell row control and result values
  always_comb begin
    ctrl       = '0;
    ctrl.sym   = symbol_in;
    count_next = count;
    fsm_next   = fsm;
    emit       = 1'b0;
    e_status   = ST_EMPTY;
    e_sym      = '0;
    e_count    = count;
    e_head     = '0;
    e_last     = 1'b1;

    if (fsm == FSM_SECOND) begin
      // second removal of a target push
      if (slot_free) begin
        ctrl.shift = 1'b1;
        emit       = 1'b1;
        e_status   = ST_REMOVED;
        e_sym      = head0;
        e_count    = count - 1'b1;
        count_next = count - 1'b1;
        e_head     = (count > CNT_W'(1)) ? head1 : '0;
        fsm_next   = FSM_IDLE;
      end
    end else if (take) begin
      unique case (kind)
        KIND_PUSH: begin
          emit = 1'b1;
          if (full) begin
            e_status = ST_FULL;
            e_head   = (count != '0) ? head0 : '0;
          end else if (symbol_in != target) begin
            // plain push into the first free cell
            ctrl.load     = 1'b1;
            ctrl.load_pos = count[IDX_W-1:0];
            count_next    = count + 1'b1;
            e_status      = ST_PUSHED;
            e_count       = count + 1'b1;
            e_head        = (count == '0) ? symbol_in : head0;
          end else if (count == '0) begin
            // target symbol alone leaves at once
            e_status = ST_REMOVED;
            e_sym    = symbol_in;
          end else begin
            // store and remove the head in one shift, one more removal follows
            ctrl.shift    = 1'b1;
            ctrl.load     = 1'b1;
            ctrl.load_pos = IDX_W'(count - 1'b1);
            e_status      = ST_REMOVED;
            e_sym         = head0;
            e_head        = (count == CNT_W'(1)) ? symbol_in : head1;
            e_last        = 1'b0;
            fsm_next      = FSM_SECOND;
          end
        end
        KIND_POP: begin
          emit = 1'b1;
          if (count != '0) begin
            ctrl.shift = 1'b1;
            count_next = count - 1'b1;
            e_status   = ST_POPPED;
            e_sym      = head0;
            e_count    = count - 1'b1;
            e_head     = (count > CNT_W'(1)) ? head1 : '0;
          end
        end
        KIND_CLEAR: begin
          emit       = 1'b1;
          count_next = '0;
          e_count    = '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= e_status;
      symbol_out  <= e_sym;
      occupancy   <= OCC_W'(e_count);
      head_symbol <= e_head;
      head_valid  <= (e_count != '0);
      last        <= e_last;
    end
  end

endmodule

### sv/bsf_checker.sv
module bsf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [2:0]                      status,
  input logic [bsf_pkg::SYM_W-1:0]       symbol_out,
  input logic [bsf_pkg::OCC_W-1:0]       occupancy,
  input logic [bsf_pkg::SYM_W-1:0]       head_symbol,
  input logic                            head_valid,
  input logic                            last
);
  import bsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol_out) && $stable(status))
    else $error("stalled result changed");

  // head flag tracks occupancy
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> head_valid == (occupancy != '0))
    else $error("head_valid does not match occupancy");

  // empty queue shows head symbol zero
  a_head_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> head_symbol == '0)
    else $error("nonzero head symbol on empty queue");

  // a successful push leaves the queue non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_PUSHED |-> head_valid)
    else $error("push left queue empty");

  // only the target rule can give a result that is not the last
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_REMOVED)
    else $error("non-final result outside target rule");

endmodule

bind bounded_symbol_fifo_with_target_drop bsf_checker u_bsf_checker (.*);

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsf_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int BURST_CAP_MAX = 40;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum bit {ROW_OP, ROW_REG} row_e;

  typedef struct {
    status_t          status;
    logic [SYM_W-1:0] sym_out;
    logic [OCC_W-1:0] occ;
    logic [SYM_W-1:0] head;
    logic             head_valid;
    logic             last_flag;
  } fifo_result_t;

  typedef struct {
    row_e             what;
    logic [1:0]       kind;
    logic [SYM_W-1:0] sym;
    reg_idx_t         idx;
    logic [CFG_W-1:0] data;
    bit               typed;
    fifo_result_t     res;
  } stim_row_t;

  // block ports
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       kind = 2'd0;
  logic [SYM_W-1:0] symbol_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       status;
  logic [SYM_W-1:0] symbol_out;
  logic [OCC_W-1:0] occupancy;
  logic [SYM_W-1:0] head_symbol;
  logic             head_valid;
  logic             last;

  bounded_symbol_fifo_with_target_drop i_dut (.*);

  // queue mirror and registers
  logic [SYM_W-1:0] ring_copy [DEPTH];
  logic [IDX_W-1:0] rd_idx = '0;
  logic [IDX_W-1:0] wr_idx = '0;
  int               held = 0;
  logic [CFG_W-1:0] cap_reg = CAP_RESET;
  logic [CFG_W-1:0] target_reg = TARGET_RESET;
  fifo_result_t     expected_results[$];
  fifo_result_t     no_typed;

  // run bookkeeping
  idle_mode_e idle_mode = IDLE_NONE;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         cycle_count = 0;
  int         mismatches = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         removals_seen = 0;
  int         refusals_seen = 0;
  stim_row_t  directed_rows[$];

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timed out, %0d results still outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

  function automatic fifo_result_t mk_res(status_t st, logic [SYM_W-1:0] s,
                                          logic [OCC_W-1:0] o, logic [SYM_W-1:0] h,
                                          logic hv, logic lst);
    fifo_result_t r;
    r.status = st;
    r.sym_out = s;
    r.occ = o;
    r.head = h;
    r.head_valid = hv;
    r.last_flag = lst;
    return r;
  endfunction

  // record one result from the queue mirror after its state change
  function automatic void post_result(status_t st, logic [SYM_W-1:0] s, logic lst);
    expected_results.push_back(mk_res(st, s, OCC_W'(held),
                                      (held != 0) ? ring_copy[rd_idx] : '0,
                                      held != 0, lst));
  endfunction

  function automatic logic [SYM_W-1:0] drop_head();
    logic [SYM_W-1:0] s;
    s = ring_copy[rd_idx];
    rd_idx = rd_idx + 1'b1;
    held--;
    return s;
  endfunction

  // expected results of one accepted operation
  function automatic void predict_queue_op(logic [1:0] k, logic [SYM_W-1:0] s);
    int               lim;
    logic [SYM_W-1:0] a;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    case (k)
      KIND_PUSH: begin
        if (held >= lim) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          ring_copy[wr_idx] = s;
          wr_idx = wr_idx + 1'b1;
          held++;
          if (s != target_reg) begin
            post_result(ST_PUSHED, '0, 1'b1);
          end else if (held < 2) begin
            a = drop_head();
            post_result(ST_REMOVED, a, 1'b1);
          end else begin
            a = drop_head();
            post_result(ST_REMOVED, a, 1'b0);
            a = drop_head();
            post_result(ST_REMOVED, a, 1'b1);
          end
        end
      end
      KIND_POP: begin
        if (held == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          a = drop_head();
          post_result(ST_POPPED, a, 1'b1);
        end
      end
      KIND_CLEAR: begin
        held = 0;
        rd_idx = '0;
        wr_idx = '0;
        post_result(ST_EMPTY, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // compare one accepted result with the oldest expectation
  function automatic void check_result();
    fifo_result_t e;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: status %0d symbol %0d", status, symbol_out);
      mismatches++;
    end else begin
      e = expected_results.pop_front();
      check_field("status", {5'b0, e.status}, {5'b0, status});
      check_field("symbol_out", e.sym_out, symbol_out);
      check_field("occupancy", e.occ, occupancy);
      check_field("head_symbol", e.head, head_symbol);
      check_field("head_valid", {7'b0, e.head_valid}, {7'b0, head_valid});
      check_field("last", {7'b0, e.last_flag}, {7'b0, last});
    end
    results_checked++;
    if (status == ST_REMOVED) removals_seen++;
    if (status == ST_FULL) refusals_seen++;
  endfunction

  function automatic int stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 85;
      IDLE_BOTH:     return 13;
      default:       return 0;
    endcase
  endfunction

  // result side: check, then choose next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) check_result();
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct());
      end
    end
  end

  task automatic sender_gap();
    int pct;
    case (idle_mode)
      IDLE_SENDER: pct = 85;
      IDLE_BOTH:   pct = 13;
      default:     pct = 0;
    endcase
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // offer one item and hold it until accepted
  task automatic offer_item(logic [1:0] k, logic [SYM_W-1:0] s, bit typed,
                            fifo_result_t typed_res);
    sender_gap();
    in_valid <= 1'b1;
    kind <= k;
    symbol_in <= s;
    do @(posedge clk); while (in_stall);
    predict_queue_op(k, s);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(typed_res);
    end
    if (k != KIND_UNUSED) items_sent++;
  endtask

  // stop sending and let every result drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAPACITY) cap_reg = v;
    else target_reg = v;
  endtask

  function automatic void add_op(logic [1:0] k, logic [SYM_W-1:0] s);
    stim_row_t r;
    r.what = ROW_OP;
    r.kind = k;
    r.sym = s;
    r.typed = 1'b0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(logic [1:0] k, logic [SYM_W-1:0] s, fifo_result_t res);
    stim_row_t r;
    r.what = ROW_OP;
    r.kind = k;
    r.sym = s;
    r.typed = 1'b1;
    r.res = res;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    stim_row_t r;
    r.what = ROW_REG;
    r.idx = idx;
    r.data = v;
    r.typed = 1'b0;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [SYM_W-1:0] plain_symbol();
    logic [SYM_W-1:0] s;
    s = SYM_W'($urandom_range(0, 255));
    if (s == target_reg) s = s ^ 8'h01;
    return s;
  endfunction

  // fill past the limit, drain a random number and refill as many so the ring wraps
  task automatic fill_and_wrap(int lim);
    int n;
    n = lim + 2;
    repeat (n) offer_item(KIND_PUSH, plain_symbol(), 1'b0, no_typed);
    n = $urandom_range(1, n);
    repeat (n) offer_item(KIND_POP, SYM_W'($urandom_range(0, 255)), 1'b0, no_typed);
    repeat (n) offer_item(KIND_PUSH, plain_symbol(), 1'b0, no_typed);
  endtask

  task automatic random_op();
    int               r;
    logic [SYM_W-1:0] s;
    r = $urandom_range(99);
    s = ($urandom_range(4) == 0) ? target_reg : SYM_W'($urandom_range(0, 255));
    if (r < 60) offer_item(KIND_PUSH, s, 1'b0, no_typed);
    else if (r < 93) offer_item(KIND_POP, s, 1'b0, no_typed);
    else if (r < 97) offer_item(KIND_CLEAR, s, 1'b0, no_typed);
    else offer_item(KIND_UNUSED, s, 1'b0, no_typed);
  endtask

  // main sequence
  initial begin
    int               lim;
    int               phase_start;
    bit               paused;
    bit               big_burst_done;
    logic [CFG_W-1:0] cap;

    // directed table: reset state, target rule, limits, ignored kind
    add_typed(KIND_POP, 8'h00, mk_res(ST_EMPTY, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1));
    add_typed(KIND_PUSH, 8'hA5, mk_res(ST_PUSHED, 8'h00, 8'd1, 8'hA5, 1'b1, 1'b1));
    add_op(KIND_PUSH, 8'h5A);
    add_op(KIND_PUSH, 8'hFF);
    add_op(KIND_PUSH, 8'h00);
    add_op(KIND_POP, 8'h00);
    add_op(KIND_PUSH, 8'h00);
    add_typed(KIND_PUSH, 8'h00, mk_res(ST_REMOVED, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1));
    add_op(KIND_UNUSED, 8'hFF);
    add_op(KIND_PUSH, 8'h3C);
    add_typed(KIND_CLEAR, 8'h00, mk_res(ST_EMPTY, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1));
    add_reg(REG_CAPACITY, 8'd0);
    add_typed(KIND_PUSH, 8'h12, mk_res(ST_FULL, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1));
    add_reg(REG_CAPACITY, 8'd2);
    add_reg(REG_TARGET, 8'hFF);
    add_op(KIND_PUSH, 8'h01);
    add_op(KIND_PUSH, 8'h02);
    add_op(KIND_PUSH, 8'h03);
    add_reg(REG_CAPACITY, 8'd1);
    add_op(KIND_PUSH, 8'h04);
    add_op(KIND_POP, 8'h00);
    add_op(KIND_PUSH, 8'hFF);
    add_reg(REG_CAPACITY, 8'd255);
    add_op(KIND_PUSH, 8'hFF);
    add_op(KIND_POP, 8'h00);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].what == ROW_REG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        offer_item(directed_rows[i].kind, directed_rows[i].sym, directed_rows[i].typed,
                   directed_rows[i].res);
      end
    end

    // random phases, each with its own setting and idling
    big_burst_done = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 7:    cap = 8'd128;
        1:       cap = 8'd4;
        2:       cap = 8'd255;
        3:       cap = 8'd1;
        5:       cap = 8'd0;
        6:       cap = CFG_W'($urandom_range(1, 255));
        default: cap = CFG_W'($urandom_range(2, BURST_CAP_MAX));
      endcase
      idle_mode = IDLE_NONE;
      write_reg(REG_CAPACITY, cap);
      write_reg(REG_TARGET, CFG_W'($urandom_range(0, 255)));
      idle_mode = idle_mode_e'(p % 4);
      lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);

      // long receiver hold while pushes keep coming
      if (p == 0) begin
        hold_req = 1'b1;
        repeat (30) offer_item(KIND_PUSH, plain_symbol(), 1'b0, no_typed);
      end

      paused = 1'b0;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (p == 4 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          settle_idle();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 6 && lim > 0 &&
            (lim <= BURST_CAP_MAX || (p == 7 && !big_burst_done))) begin
          if (lim > BURST_CAP_MAX) big_burst_done = 1'b1;
          fill_and_wrap(lim);
        end else begin
          random_op();
        end
      end
    end

    // drain and finish
    settle_idle();
    $display("covered %0d items and %0d results in the directed table and %0d random phases",
             items_sent, results_checked, PHASES);
    $display("target removals %0d, full refusals %0d, mismatches %0d", removals_seen,
             refusals_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bsf_pkg.sv
sv/bsf_cell.sv
sv/bsf_chain.sv
sv/bounded_symbol_fifo_with_target_drop.sv
sv/bsf_checker.sv
tb/tb_top.sv
